// ===== design/pdm_pkg.sv =====
// Package for the PWM period and duty meter.
// Holds the shared types, the sequencer states and the field constants.
// No dependencies.
package pdm_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned RateW         = 24;
  localparam int unsigned FieldW        = 16;
  localparam int unsigned DutyW         = 7;
  localparam int unsigned DutyScale     = 100;
  localparam logic [23:0] RateResetVal  = 24'd250000;

  // Status of one captured tick, handed from the capture logic to the sequencer.
  typedef struct packed {
    logic emit;   // the tick produces a result
    logic mark;   // measurement valid mark after this tick
    logic zero;   // numeric results are all zero
  } cap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUTY_GO,
    ST_DUTY_RUN,
    ST_FREQ_GO,
    ST_FREQ_RUN,
    ST_OUT
  } seq_state_e;

endpackage

// ===== design/pdm_capture.sv =====
// Tick counter and edge capture of the PWM period and duty meter.
// Depends on pdm_pkg for the capture status struct.
module pdm_capture #(
  parameter int unsigned COUNT_WIDTH = pdm_pkg::CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   level_i,
  output pdm_pkg::cap_t          cap_o,
  output logic [COUNT_WIDTH-1:0] high_o,
  output logic [COUNT_WIDTH-1:0] period_o
);
  import pdm_pkg::*;

  logic [COUNT_WIDTH-1:0] tick_q, tick_d, cnt_inc;
  logic [COUNT_WIDTH-1:0] held_q, held_d;
  logic                   expect_q, expect_d;
  logic                   last_q;
  logic                   mark_q, mark_d;
  logic                   wrapped, take_rise, take_fall;

  always_comb begin
    cnt_inc   = tick_q + COUNT_WIDTH'(1);
    wrapped   = (cnt_inc == '0);
    take_rise = !expect_q && level_i && !last_q;
    take_fall = expect_q && !level_i && last_q;

    // A rising edge wins over a wrap on the same tick.
    if (take_rise) begin
      mark_d = 1'b1;
    end else if (wrapped) begin
      mark_d = 1'b0;
    end else begin
      mark_d = mark_q;
    end

    tick_d   = take_rise ? '0 : cnt_inc;
    held_d   = take_fall ? cnt_inc : held_q;
    expect_d = take_rise ? 1'b1 : (take_fall ? 1'b0 : expect_q);

    period_o   = take_rise ? cnt_inc : '0;
    high_o     = take_rise ? held_q : '0;
    cap_o.emit = wrapped || take_rise;
    cap_o.mark = mark_d;
    cap_o.zero = !mark_d || (period_o == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      held_q   <= '0;
      expect_q <= 1'b0;
      last_q   <= 1'b0;
      mark_q   <= 1'b0;
    end else if (step_i) begin
      tick_q   <= tick_d;
      held_q   <= held_d;
      expect_q <= expect_d;
      last_q   <= level_i;
      mark_q   <= mark_d;
    end
  end

endmodule

// ===== design/pdm_div.sv =====
// Shared restoring divider of the PWM period and duty meter, one quotient bit per cycle.
// Depends on pdm_pkg only through the common import convention.
module pdm_div #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  import pdm_pkg::*;

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [CntW-1:0]  cnt_q;
  logic             done_q;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_o && (cnt_q == CntW'(1));
      if (start_i) begin
        cnt_q <= CntW'(NUM_W);
      end else if (busy_o) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // The numerator shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_o) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== design/pwm_period_duty_meter.sv =====
// Top level of the PWM period and duty meter: sequencer, configuration and output register.
// Depends on pdm_pkg, pdm_capture and pdm_div.
//
// Usage: each transfer on the input channel is one timer tick with the sampled
// signal level. A free-running counter of COUNT_WIDTH bits measures the signal;
// a falling edge captures the high time, the next rising edge captures the
// period and restarts the counter. On a rising edge or a counter wrap one
// result is sent on the output channel: valid mark, high time, period, duty in
// percent and frequency (tick rate / period). A tick without a result keeps
// input ready high. A tick whose result is all zero (a wrap or a zero period)
// skips the divisions and goes straight to the output state. Any other result
// runs two divisions, in the duty and then the frequency states, on one shared
// bit-serial divider of NUM_W = max(COUNT_WIDTH + 7, 24) steps each, then goes
// to the output state. In both cases input ready returns when the result is
// loaded. While the receiver stalls, ticks that give no result are still taken;
// a tick that gives one waits at the end of its computation until the output
// register is free. Reset clears the counter and the edge state, empties the
// output register and sets the tick rate to 250000. The tick rate is written
// through cfg_we_i / cfg_wdata_i; the user must write it only while idle, the block does not enforce this.
module pwm_period_duty_meter #(
  parameter int unsigned COUNT_WIDTH = pdm_pkg::CountWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pdm_pkg::RateW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            signal_level_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            measure_valid_o,
  output logic [pdm_pkg::FieldW-1:0]      high_ticks_o,
  output logic [pdm_pkg::FieldW-1:0]      period_ticks_o,
  output logic [pdm_pkg::DutyW-1:0]       duty_percent_o,
  output logic [pdm_pkg::RateW-1:0]       frequency_hz_o
);
  import pdm_pkg::*;

  localparam int unsigned NumW = (COUNT_WIDTH + DutyW > RateW) ? COUNT_WIDTH + DutyW : RateW;

  seq_state_e             state_q, state_d;
  logic [RateW-1:0]       rate_q;
  cap_t                   cap;
  logic [COUNT_WIDTH-1:0] cap_high, cap_period;
  logic                   in_xfer, out_xfer, load_out;

  logic                   mark_q;
  logic [COUNT_WIDTH-1:0] high_q, period_q;
  logic [DutyW-1:0]       duty_q;
  logic [RateW-1:0]       freq_q;
  logic [FieldW-1:0]      high_sat, period_sat;

  logic                   out_valid_q;
  logic                   out_mark_q;
  logic [FieldW-1:0]      out_high_q, out_period_q;
  logic [DutyW-1:0]       out_duty_q;
  logic [RateW-1:0]       out_freq_q;

  logic                   div_start, div_busy, div_done;
  logic [NumW-1:0]        div_num, div_quot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;

  pdm_capture #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_xfer),
    .level_i (signal_level_i),
    .cap_o   (cap),
    .high_o  (cap_high),
    .period_o(cap_period)
  );

  pdm_div #(
    .NUM_W(NumW),
    .DEN_W(COUNT_WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (period_q),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = NumW'(rate_q);
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && cap.emit) begin
          state_d = cap.zero ? ST_OUT : ST_DUTY_GO;
        end
      end
      ST_DUTY_GO: begin
        div_start = 1'b1;
        div_num   = NumW'(high_q) * NumW'(DutyScale);
        state_d   = ST_DUTY_RUN;
      end
      ST_DUTY_RUN: begin
        if (div_done) begin
          state_d = ST_FREQ_GO;
        end
      end
      ST_FREQ_GO: begin
        div_start = 1'b1;
        state_d   = ST_FREQ_RUN;
      end
      ST_FREQ_RUN: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= RateResetVal;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Job registers: counts are cleared here when the results must read as zero.
  always_ff @(posedge clk_i) begin
    if (in_xfer && cap.emit) begin
      mark_q   <= cap.mark;
      high_q   <= cap.zero ? '0 : cap_high;
      period_q <= cap.zero ? '0 : cap_period;
      duty_q   <= '0;
      freq_q   <= '0;
    end
    if (state_q == ST_DUTY_RUN && div_done) begin
      // A high time not below the period saturates the duty at full scale.
      duty_q <= (high_q >= period_q) ? DutyW'(DutyScale) : div_quot[DutyW-1:0];
    end
    if (state_q == ST_FREQ_RUN && div_done) begin
      freq_q <= div_quot[RateW-1:0];
    end
  end

  if (COUNT_WIDTH > FieldW) begin : g_sat
    assign high_sat   = (|high_q[COUNT_WIDTH-1:FieldW]) ? '1 : high_q[FieldW-1:0];
    assign period_sat = (|period_q[COUNT_WIDTH-1:FieldW]) ? '1 : period_q[FieldW-1:0];
  end else begin : g_ext
    assign high_sat   = FieldW'(high_q);
    assign period_sat = FieldW'(period_q);
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_mark_q   <= mark_q;
      out_high_q   <= high_sat;
      out_period_q <= period_sat;
      out_duty_q   <= duty_q;
      out_freq_q   <= freq_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign measure_valid_o = out_mark_q;
  assign high_ticks_o    = out_high_q;
  assign period_ticks_o  = out_period_q;
  assign duty_percent_o  = out_duty_q;
  assign frequency_hz_o  = out_freq_q;

`ifndef SYNTHESIS
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_percent_o <= DutyW'(DutyScale))
    else $error("duty above full scale");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !measure_valid_o) |->
      (high_ticks_o == '0 && period_ticks_o == '0 && duty_percent_o == '0 &&
       frequency_hz_o == '0))
    else $error("invalid measurement with nonzero results");

  a_zero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && period_ticks_o == '0) |->
      (high_ticks_o == '0 && duty_percent_o == '0 && frequency_hz_o == '0))
    else $error("zero period with nonzero results");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> period_q != '0)
    else $error("division by a zero period");
`endif

endmodule
